[hdl/etb_pkg.sv]
// Shared constants and types of the elimination tree builder.
package etb_pkg;

	localparam int MAX_ORDER = 1024;
	localparam int IDX_W     = 10;
	localparam int EPOCH_W   = 6;
	localparam int CNT_W     = $clog2(MAX_ORDER);

	// Tag zero is kept for entries that no matrix has written.
	localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	localparam logic [IDX_W:0] ORDER_LIMIT = (IDX_W + 1)'(MAX_ORDER);

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [IDX_W-1:0]   link;
	} entry_t;

endpackage

[hdl/elimination_tree_builder_unit.sv]
// Elimination tree builder: ancestor walk with path compression over one memory.
// Busy stays high while a request walks; a walk that ends on an unlinked node gives a
// registered result strobe as busy falls, one that meets a link at or above the column
// gives none. Ignored requests release at once unless they start a clear; results
// never stall. Reset and every 63rd first_of_matrix start a clearing pass over all
// MAX_ORDER (1024) entries with busy high; a live request then has a lookup state first.
module elimination_tree_builder_unit
	import etb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             first_of_matrix,
	input  logic [IDX_W-1:0] col_index,
	input  logic [IDX_W-1:0] row_index,
	output logic             result_valid,
	output logic [IDX_W-1:0] child_node,
	output logic [IDX_W-1:0] parent_node
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_LOOKUP,
		ST_WALK
	} state_t;

	state_t             state_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CNT_W-1:0]   clr_cnt_q;
	logic               live_q;
	logic [IDX_W-1:0]   node_q;
	logic [IDX_W-1:0]   col_q;
	logic               strobe_q;
	logic [IDX_W-1:0]   child_q;
	logic [IDX_W-1:0]   parent_q;

	entry_t             mem [MAX_ORDER];
	entry_t             rd_q;
	logic [CNT_W-1:0]   rd_addr;
	logic               wr_en;
	logic [CNT_W-1:0]   wr_addr;
	entry_t             wr_data;

	logic accept;
	logic live_in;
	logic wrap;
	logic had;
	logic go_on;

	assign accept  = start && (state_q == ST_IDLE);
	assign live_in = (row_index < col_index) && ({1'b0, col_index} < ORDER_LIMIT)
		&& ({1'b0, row_index} < ORDER_LIMIT);
	assign wrap    = first_of_matrix && (epoch_q == EPOCH_LAST);
	assign had     = (rd_q.tag == epoch_q);
	assign go_on   = rd_q.link < col_q;

	always_comb begin
		rd_addr = CNT_W'(node_q);
		wr_en   = 1'b0;
		wr_addr = CNT_W'(node_q);
		wr_data = '{tag: epoch_q, link: col_q};
		case (state_q)
			ST_IDLE: begin
				rd_addr = CNT_W'(row_index);
			end
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '{tag: EPOCH_NONE, link: '0};
			end
			ST_LOOKUP: begin
				rd_addr = CNT_W'(node_q);
			end
			ST_WALK: begin
				// point the visited node at the column, fetch its old ancestor
				wr_en   = 1'b1;
				rd_addr = CNT_W'(rd_q.link);
			end
			default: begin
				rd_addr = CNT_W'(node_q);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			epoch_q   <= EPOCH_FIRST;
			clr_cnt_q <= '0;
			live_q    <= 1'b0;
			node_q    <= '0;
			col_q     <= '0;
			strobe_q  <= 1'b0;
			child_q   <= '0;
			parent_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						node_q <= row_index;
						col_q  <= col_index;
						live_q <= live_in;
						if (wrap) begin
							epoch_q   <= EPOCH_FIRST;
							clr_cnt_q <= '0;
							state_q   <= ST_CLEAR;
						end else begin
							if (first_of_matrix) begin
								epoch_q <= epoch_q + EPOCH_W'(1);
							end
							if (live_in) begin
								state_q <= ST_WALK;
							end
						end
					end
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + CNT_W'(1);
					if (clr_cnt_q == CNT_W'(MAX_ORDER - 1)) begin
						state_q <= live_q ? ST_LOOKUP : ST_IDLE;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (!had) begin
						// chain ends here: the column is this node's parent
						strobe_q <= 1'b1;
						child_q  <= node_q;
						parent_q <= col_q;
						state_q  <= ST_IDLE;
					end else if (go_on) begin
						node_q <= rd_q.link;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = strobe_q;
	assign child_node   = child_q;
	assign parent_node  = parent_q;

endmodule

[hdl/etb_checker.sv]
// Port-level checks of the elimination tree builder, bound to the top level.
module etb_checker
	import etb_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             first_of_matrix,
	input logic [IDX_W-1:0] col_index,
	input logic [IDX_W-1:0] row_index,
	input logic             result_valid,
	input logic [IDX_W-1:0] child_node,
	input logic [IDX_W-1:0] parent_node
);

	// a parent always sits above its child
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (parent_node > child_node))
		else $error("parent not above child");

	// the block is free again when a result is shown
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("busy while result shown");

	// no result can follow a request in the very next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("result too early");

	// an ignored request without a clear releases at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !first_of_matrix && (row_index >= col_index)) |=> !busy)
		else $error("ignored request held busy");

endmodule

bind elimination_tree_builder_unit etb_checker u_etb_checker (.*);

[test/testbench.sv]
// Self-checking testbench for the elimination tree builder unit.
`timescale 1ns / 100ps

module testbench;
	import etb_pkg::*;

	localparam int ITEM_TARGET    = 1550;
	localparam int IDLE_PERCENT   = 24;
	localparam int STALL_LIMIT    = 8000;
	localparam int DRAIN_CYCLES   = 1100;

	typedef struct packed {
		logic [IDX_W-1:0] child;
		logic [IDX_W-1:0] parent;
	} tree_arc_t;

	// Tracks the ancestor links and the tree arcs still owed by the block.
	class etree_scoreboard;
		logic [IDX_W-1:0] link_to [MAX_ORDER];
		bit               linked  [MAX_ORDER];
		tree_arc_t        owed_arcs [$];
		int               errors;

		function void note_request(bit first, logic [IDX_W-1:0] col,
				logic [IDX_W-1:0] row);
			logic [IDX_W-1:0] node;
			logic [IDX_W-1:0] next_node;
			bit               had;
			int               steps;
			tree_arc_t        arc;
			if (first)
				foreach (linked[i]) linked[i] = 0;
			node = row;
			// walk the chain, pointing every visited node at the column
			for (steps = 0; steps < MAX_ORDER && node < col; steps++) begin
				had = linked[node];
				next_node = link_to[node];
				link_to[node] = col;
				linked[node] = 1;
				if (!had) begin
					arc.child = node;
					arc.parent = col;
					owed_arcs.push_back(arc);
					return;
				end
				node = next_node;
			end
		endfunction

		function void check_result(logic [IDX_W-1:0] child, logic [IDX_W-1:0] parent);
			tree_arc_t arc;
			if (owed_arcs.size() == 0) begin
				$display("%0t: unexpected result child=%0d parent=%0d", $time, child, parent);
				errors++;
				return;
			end
			arc = owed_arcs.pop_front();
			if (child !== arc.child) begin
				$display("%0t: child_node expected %0d actual %0d", $time, arc.child, child);
				errors++;
			end
			if (parent !== arc.parent) begin
				$display("%0t: parent_node expected %0d actual %0d", $time, arc.parent, parent);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             first_of_matrix;
	logic [IDX_W-1:0] col_index;
	logic [IDX_W-1:0] row_index;
	logic             result_valid;
	logic [IDX_W-1:0] child_node;
	logic [IDX_W-1:0] parent_node;

	etree_scoreboard tree_sb;
	bit              idle_on;
	int              requests_sent;
	int              quiet_cycles;

	elimination_tree_builder_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.first_of_matrix (first_of_matrix),
		.col_index       (col_index),
		.row_index       (row_index),
		.result_valid    (result_valid),
		.child_node      (child_node),
		.parent_node     (parent_node)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Check results before noting a new request; the result always belongs to an older one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				tree_sb.check_result(child_node, parent_node);
			if (start && !busy)
				tree_sb.note_request(first_of_matrix, col_index, row_index);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic drive_request(bit first, int col, int row);
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		first_of_matrix <= first;
		col_index <= IDX_W'(col);
		row_index <= IDX_W'(row);
		do @(posedge clk); while (busy);
		@(negedge clk);
		requests_sent++;
	endtask

	// One well-formed matrix: random span, sorted columns, rows mostly below the column.
	task automatic drive_matrix();
		int span;
		int base;
		int count;
		int cols [$];
		int row;
		int pick;
		if ($urandom_range(19) == 0)
			span = $urandom_range(200, MAX_ORDER);
		else
			span = $urandom_range(2, 40);
		base = $urandom_range(0, MAX_ORDER - span);
		count = $urandom_range(span, 2 * span);
		if (count > 80)
			count = $urandom_range(40, 80);
		for (int i = 0; i < count; i++)
			cols.push_back(base + $urandom_range(0, span - 1));
		cols.sort();
		foreach (cols[i]) begin
			pick = $urandom_range(99);
			if (cols[i] == base || pick < 8)
				row = $urandom_range(cols[i], base + span - 1);
			else if (pick < 38)
				row = cols[i] - $urandom_range(1, (cols[i] - base < 3) ? cols[i] - base : 3);
			else
				row = $urandom_range(base, cols[i] - 1);
			drive_request(i == 0, cols[i], row);
		end
	endtask

	// Random fields, columns out of order, stray clears.
	task automatic drive_noise();
		int count;
		count = $urandom_range(3, 12);
		for (int i = 0; i < count; i++)
			drive_request($urandom_range(19) == 0, $urandom_range(0, MAX_ORDER - 1),
				$urandom_range(0, MAX_ORDER - 1));
	endtask

	initial begin
		tree_sb = new();
		idle_on = 1'b1;
		requests_sent = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		first_of_matrix = 1'b0;
		col_index = '0;
		row_index = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// row equal to column, extremes of both fields
		drive_request(1, 0, 0);
		drive_request(1, MAX_ORDER - 1, 0);
		drive_request(0, MAX_ORDER - 1, MAX_ORDER - 2);
		drive_request(0, MAX_ORDER - 1, 0);
		drive_request(0, MAX_ORDER - 1, MAX_ORDER - 1);
		// row above column
		drive_request(0, 5, 900);
		// short chain with path compression
		drive_request(1, 2, 1);
		drive_request(0, 3, 1);
		drive_request(0, 3, 2);
		drive_request(0, 4, 1);
		drive_request(0, 6, 1);
		drive_request(0, 6, 0);
		// column out of order: walk stops on a node above the column
		drive_request(0, 2, 0);
		drive_request(0, 1, 0);
		// clear on an ignored request still takes effect
		drive_request(1, 0, 5);
		drive_request(0, 5, 1);
		drive_request(0, 5, 4);
		drive_request(0, 682, 341);
		drive_request(0, 1022, 341);

		while (requests_sent < ITEM_TARGET) begin
			// hold a long stretch without idling in the middle of the run
			idle_on = !(requests_sent > 600 && requests_sent < 900);
			if ($urandom_range(99) < 85)
				drive_matrix();
			else
				drive_noise();
		end
		start <= 1'b0;

		while (tree_sb.owed_arcs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tree_sb.owed_arcs.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, tree_sb.owed_arcs.size());
			tree_sb.errors++;
		end
		if (tree_sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
hdl/etb_pkg.sv
hdl/elimination_tree_builder_unit.sv
hdl/etb_checker.sv
test/testbench.sv
